>>> src/multilevel_feedback_queue_scheduler_assert.svh
// Assertion macros for the multilevel feedback queue scheduler.
`ifndef MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_ASSERT_SVH
`define MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define MFQS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scheduler assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define MFQS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scheduler assertion failed");

`endif

>>> src/mfqs_pkg.sv
// Shared types and constants of the multilevel feedback queue scheduler.
package mfqs_pkg;

  localparam int LEVEL_W = 3;
  localparam int ID_W    = 8;
  localparam int BURST_W = 16;
  localparam int SLICE_W = 16;

  localparam logic [SLICE_W-1:0] SLICE_RESET = 16'd2;

  localparam logic OP_ADMIT    = 1'b0;
  localparam logic OP_DISPATCH = 1'b1;

  typedef enum logic [2:0] {
    ST_ADMITTED  = 3'd0,
    ST_REFUSED   = 3'd1,
    ST_REQUEUED  = 3'd2,
    ST_COMPLETED = 3'd3,
    ST_DROPPED   = 3'd4,
    ST_IDLE      = 3'd5
  } mfqs_status_t;

  typedef struct packed {
    logic               operation;
    logic [LEVEL_W-1:0] level;
    logic [ID_W-1:0]    pid;
    logic [BURST_W-1:0] burst;
  } mfqs_in_t;

  typedef struct packed {
    mfqs_status_t       status;
    logic [ID_W-1:0]    served_id;
    logic [LEVEL_W-1:0] served_level;
    logic [BURST_W-1:0] remaining;
    logic [LEVEL_W-1:0] next_level;
  } mfqs_out_t;

endpackage

>>> src/multilevel_feedback_queue_scheduler.sv
// Multilevel feedback queue scheduler: sequencer, queue pointers and result register.
// An admit passes through the admit and finish states; a dispatch scans the levels from the
// scan pointer, one level per cycle, then reads, pushes and finishes.
// A dispatch that finds every queue empty scans all LEVELS levels and then finishes.
// The next item is taken the cycle after its result is loaded.
// Synchronous reset empties all queues, zeroes the scan pointer and sets the time slice to 2.
module multilevel_feedback_queue_scheduler #(
  parameter int LEVELS     = 5,
  parameter int DEPTH      = 8,
  parameter int ID_BITS    = 8,
  parameter int BURST_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  mfqs_pkg::mfqs_in_t        in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output mfqs_pkg::mfqs_out_t       out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [mfqs_pkg::SLICE_W-1:0] cfg_data
);

  import mfqs_pkg::*;

  localparam int LW    = $clog2(LEVELS);
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int N     = LEVELS * DEPTH;
  localparam int AW    = $clog2(N);
  localparam int DW    = ID_BITS + BURST_BITS;
  localparam int W1    = (BURST_BITS > SLICE_W) ? BURST_BITS : SLICE_W;
  localparam int ALU_W = (W1 > CW) ? W1 : CW;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_ADMIT  = 6'b000010,
    S_SCAN   = 6'b000100,
    S_READ   = 6'b001000,
    S_PUSH   = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [LEVEL_W-1:0]     lvl_raw_r, lvl_raw_nxt;
  logic                   lvl_ok_r, lvl_ok_nxt;
  logic [ID_BITS-1:0]     id_r, id_nxt;
  logic [BURST_BITS-1:0]  burst_r, burst_nxt;
  logic [LW-1:0]          cur_r, cur_nxt;
  logic [LW-1:0]          served_r, served_nxt;
  logic [LW-1:0]          steps_r, steps_nxt;
  logic [LW-1:0]          scan_r, scan_nxt;
  logic [SLICE_W-1:0]     slice_r, slice_nxt;
  mfqs_out_t              res_r, res_nxt;
  logic                   out_valid_r, out_valid_nxt;
  mfqs_out_t              out_data_r, out_data_nxt;
  logic [PW-1:0]          head_r [LEVELS];
  logic [PW-1:0]          head_nxt [LEVELS];
  logic [PW-1:0]          tail_r [LEVELS];
  logic [PW-1:0]          tail_nxt [LEVELS];
  logic [CW-1:0]          cnt_r [LEVELS];
  logic [CW-1:0]          cnt_nxt [LEVELS];

  logic [ALU_W-1:0]       alu_a, alu_b, alu_diff;
  logic                   alu_borrow;
  logic                   mem_we, mem_re;
  logic [AW-1:0]          mem_waddr, mem_raddr, base_addr;
  logic [DW-1:0]          mem_wdata, mem_rdata;
  logic [LW-1:0]          cur_next_lvl;
  logic [ID_BITS-1:0]     rd_id;
  logic [BURST_BITS-1:0]  rd_burst;

  mfqs_alu #(.W(ALU_W)) u_alu (
    .a      (alu_a),
    .b      (alu_b),
    .diff   (alu_diff),
    .borrow (alu_borrow)
  );

  mfqs_entry_mem #(.N(N), .AW(AW), .DW(DW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_ready     = (state_r == S_IDLE);
  assign cfg_ready    = 1'b1;
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;
  assign base_addr    = AW'(cur_r) * AW'(DEPTH);
  assign cur_next_lvl = (cur_r == LW'(LEVELS - 1)) ? '0 : cur_r + 1'b1;
  assign rd_id        = mem_rdata[DW-1:BURST_BITS];
  assign rd_burst     = mem_rdata[BURST_BITS-1:0];
  assign mem_wdata    = {id_r, burst_r};
  assign mem_waddr    = base_addr + AW'(tail_r[cur_r]);
  assign mem_raddr    = base_addr + AW'(head_r[cur_r]);

  always_comb begin
    alu_a = '0;
    alu_b = '0;
    unique case (state_r)
      S_SCAN: begin
        alu_b = ALU_W'(cnt_r[cur_r]);
      end
      S_ADMIT, S_PUSH: begin
        alu_a = ALU_W'(cnt_r[cur_r]);
        alu_b = ALU_W'(DEPTH);
      end
      S_READ: begin
        alu_a = ALU_W'(rd_burst);
        alu_b = ALU_W'(slice_r);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    lvl_raw_nxt   = lvl_raw_r;
    lvl_ok_nxt    = lvl_ok_r;
    id_nxt        = id_r;
    burst_nxt     = burst_r;
    cur_nxt       = cur_r;
    served_nxt    = served_r;
    steps_nxt     = steps_r;
    scan_nxt      = scan_r;
    slice_nxt     = slice_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    cnt_nxt       = cnt_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;

    if (cfg_valid && cfg_ready) begin
      slice_nxt = cfg_data;
    end
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          lvl_raw_nxt = in_data.level;
          id_nxt      = ID_BITS'(in_data.pid);
          burst_nxt   = BURST_BITS'(in_data.burst);
          if (in_data.operation == OP_DISPATCH) begin
            cur_nxt   = scan_r;
            steps_nxt = '0;
            state_nxt = S_SCAN;
          end else begin
            lvl_ok_nxt = (32'(in_data.level) < LEVELS);
            cur_nxt    = (32'(in_data.level) < LEVELS) ? LW'(in_data.level) : '0;
            state_nxt  = S_ADMIT;
          end
        end
      end
      S_ADMIT: begin
        res_nxt.served_id    = ID_W'(id_r);
        res_nxt.served_level = lvl_raw_r;
        res_nxt.remaining    = BURST_W'(burst_r);
        if (lvl_ok_r && alu_borrow) begin
          mem_we               = 1'b1;
          tail_nxt[cur_r]      = (tail_r[cur_r] == PW'(DEPTH - 1)) ? '0 : tail_r[cur_r] + 1'b1;
          cnt_nxt[cur_r]       = cnt_r[cur_r] + 1'b1;
          res_nxt.status       = ST_ADMITTED;
          res_nxt.next_level   = lvl_raw_r;
        end else begin
          res_nxt.status       = ST_REFUSED;
          res_nxt.next_level   = '0;
        end
        state_nxt = S_FINISH;
      end
      S_SCAN: begin
        if (alu_borrow) begin
          mem_re          = 1'b1;
          head_nxt[cur_r] = (head_r[cur_r] == PW'(DEPTH - 1)) ? '0 : head_r[cur_r] + 1'b1;
          cnt_nxt[cur_r]  = cnt_r[cur_r] - 1'b1;
          served_nxt      = cur_r;
          state_nxt       = S_READ;
        end else if (steps_r == LW'(LEVELS - 1)) begin
          res_nxt.status       = ST_IDLE;
          res_nxt.served_id    = '0;
          res_nxt.served_level = '0;
          res_nxt.remaining    = '0;
          res_nxt.next_level   = '0;
          state_nxt            = S_FINISH;
        end else begin
          cur_nxt   = cur_next_lvl;
          steps_nxt = steps_r + 1'b1;
        end
      end
      S_READ: begin
        id_nxt    = rd_id;
        burst_nxt = alu_borrow ? '0 : BURST_BITS'(alu_diff);
        cur_nxt   = cur_next_lvl;
        scan_nxt  = cur_next_lvl;
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        res_nxt.served_id    = ID_W'(id_r);
        res_nxt.served_level = LEVEL_W'(served_r);
        if (burst_r == '0) begin
          res_nxt.status     = ST_COMPLETED;
          res_nxt.remaining  = '0;
          res_nxt.next_level = '0;
        end else begin
          res_nxt.remaining  = BURST_W'(burst_r);
          res_nxt.next_level = LEVEL_W'(cur_r);
          if (alu_borrow) begin
            mem_we          = 1'b1;
            tail_nxt[cur_r] = (tail_r[cur_r] == PW'(DEPTH - 1)) ? '0 : tail_r[cur_r] + 1'b1;
            cnt_nxt[cur_r]  = cnt_r[cur_r] + 1'b1;
            res_nxt.status  = ST_REQUEUED;
          end else begin
            res_nxt.status  = ST_DROPPED;
          end
        end
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      scan_r      <= '0;
      slice_r     <= SLICE_RESET;
      out_valid_r <= 1'b0;
      cur_r       <= '0;
      steps_r     <= '0;
      for (int i = 0; i < LEVELS; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      scan_r      <= scan_nxt;
      slice_r     <= slice_nxt;
      out_valid_r <= out_valid_nxt;
      cur_r       <= cur_nxt;
      steps_r     <= steps_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lvl_raw_r  <= lvl_raw_nxt;
    lvl_ok_r   <= lvl_ok_nxt;
    id_r       <= id_nxt;
    burst_r    <= burst_nxt;
    served_r   <= served_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  `include "multilevel_feedback_queue_scheduler_assert.svh"

  `MFQS_ASSERT_NEXT(a_busy_after_transfer, in_valid && in_ready, !in_ready)
  `MFQS_ASSERT_SAME(a_count_bounded, 1'b1, 32'(cnt_r[cur_r]) <= DEPTH)
  `MFQS_ASSERT_SAME(a_completed_fields, out_valid && out_data.status == ST_COMPLETED,
                    out_data.remaining == '0 && out_data.next_level == '0)
  `MFQS_ASSERT_NEXT(a_scan_moves, state_r == S_READ, scan_r == $past(cur_next_lvl))

endmodule

>>> src/mfqs_alu.sv
// Shared subtractor that also serves as the compare unit of the sequencer.
module mfqs_alu #(
  parameter int W = 16
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] diff,
  output logic         borrow
);

  logic [W:0] full;

  assign full   = {1'b0, a} - {1'b0, b};
  assign diff   = full[W-1:0];
  assign borrow = full[W];

endmodule

>>> src/mfqs_entry_mem.sv
// Entry store of all queue levels with one write port and one registered read port.
module mfqs_entry_mem #(
  parameter int N  = 40,
  parameter int AW = 6,
  parameter int DW = 24
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [N];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> tb/sv/tb_multilevel_feedback_queue_scheduler.sv
// Self-checking testbench for the multilevel feedback queue scheduler.
module tb_multilevel_feedback_queue_scheduler;
  import mfqs_pkg::*;

  localparam int LEVELS    = 5;
  localparam int DEPTH     = 8;
  localparam int PHASE_LEN = 250;

  class sched_scoreboard_t;
    logic [ID_W-1:0]    ids    [LEVELS*DEPTH];
    logic [BURST_W-1:0] bursts [LEVELS*DEPTH];
    int                 head   [LEVELS];
    int                 tail   [LEVELS];
    int                 fill   [LEVELS];
    int                 scan;
    logic [SLICE_W-1:0] slice;
    mfqs_out_t          awaited_results [$];
    int                 failures;

    function new();
      for (int i = 0; i < LEVELS; i++) begin
        head[i] = 0;
        tail[i] = 0;
        fill[i] = 0;
      end
      scan     = 0;
      slice    = SLICE_RESET;
      failures = 0;
    endfunction

    function void set_slice(logic [SLICE_W-1:0] value);
      slice = value;
    endfunction

    function bit enqueue(int lv, logic [ID_W-1:0] id, logic [BURST_W-1:0] b);
      int slot;
      if (lv >= LEVELS || fill[lv] >= DEPTH) return 1'b0;
      slot         = lv * DEPTH + tail[lv];
      ids[slot]    = id;
      bursts[slot] = b;
      tail[lv]     = (tail[lv] + 1) % DEPTH;
      fill[lv]++;
      return 1'b1;
    endfunction

    function void note_item(mfqs_in_t item);
      mfqs_out_t          r;
      int                 served;
      int                 slot;
      int                 target;
      bit                 found;
      logic [ID_W-1:0]    sid;
      logic [BURST_W-1:0] sb;
      logic [BURST_W-1:0] rem;
      r = '0;
      if (item.operation == OP_ADMIT) begin
        r.served_id    = item.pid;
        r.served_level = item.level;
        r.remaining    = item.burst;
        if (enqueue(int'(item.level), item.pid, item.burst)) begin
          r.status     = ST_ADMITTED;
          r.next_level = item.level;
        end else begin
          r.status = ST_REFUSED;
        end
      end else begin
        found  = 1'b0;
        served = 0;
        for (int k = 0; k < LEVELS; k++) begin
          if (!found && fill[(scan + k) % LEVELS] != 0) begin
            served = (scan + k) % LEVELS;
            found  = 1'b1;
          end
        end
        if (!found) begin
          r.status = ST_IDLE;
        end else begin
          slot         = served * DEPTH + head[served];
          sid          = ids[slot];
          sb           = bursts[slot];
          head[served] = (head[served] + 1) % DEPTH;
          fill[served]--;
          rem          = (sb > slice) ? sb - slice : '0;
          target       = (served + 1) % LEVELS;
          scan         = target;
          r.served_id    = sid;
          r.served_level = LEVEL_W'(served);
          r.remaining    = rem;
          if (rem == 0) begin
            r.status    = ST_COMPLETED;
            r.remaining = '0;
          end else if (enqueue(target, sid, rem)) begin
            r.status     = ST_REQUEUED;
            r.next_level = LEVEL_W'(target);
          end else begin
            r.status     = ST_DROPPED;
            r.next_level = LEVEL_W'(target);
          end
        end
      end
      awaited_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s expected %0d actual %0d", name, exp_v, act_v);
        failures++;
      end
    endfunction

    function void check_result(mfqs_out_t got);
      mfqs_out_t want;
      if (awaited_results.size() == 0) begin
        $error("result transfer with no result awaited");
        failures++;
        return;
      end
      want = awaited_results.pop_front();
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("served_id", 32'(want.served_id), 32'(got.served_id));
      compare_field("served_level", 32'(want.served_level), 32'(got.served_level));
      compare_field("remaining", 32'(want.remaining), 32'(got.remaining));
      compare_field("next_level", 32'(want.next_level), 32'(got.next_level));
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  mfqs_in_t           in_data;
  logic               out_valid;
  logic               out_ready;
  mfqs_out_t          out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [SLICE_W-1:0] cfg_data;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          long_stall_pending;
  int          hold_left;

  sched_scoreboard_t tracker = new();

  multilevel_feedback_queue_scheduler #(
    .LEVELS    (LEVELS),
    .DEPTH     (DEPTH),
    .ID_BITS   (ID_W),
    .BURST_BITS(BURST_W)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      tracker.check_result(out_data);
    end
    if (long_stall_pending) begin
      long_stall_pending = 1'b0;
      hold_left          = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic mfqs_in_t make_item(logic op, int lv, int id, int b);
    mfqs_in_t it;
    it.operation = op;
    it.level     = LEVEL_W'(lv);
    it.pid       = ID_W'(id);
    it.burst     = BURST_W'(b);
    return it;
  endfunction

  function automatic mfqs_in_t random_item(int unsigned admit_pct);
    mfqs_in_t    it;
    int unsigned span;
    it.operation  = ($urandom_range(99) < admit_pct) ? OP_ADMIT : OP_DISPATCH;
    it.level      = ($urandom_range(9) == 0) ? LEVEL_W'($urandom_range(7, 5))
                                             : LEVEL_W'($urandom_range(LEVELS - 1));
    it.pid        = ID_W'($urandom_range(255));
    span          = 4 * int'(tracker.slice);
    if (span > 65535) span = 65535;
    it.burst      = ($urandom_range(7) == 0) ? BURST_W'($urandom_range(65535))
                                             : BURST_W'($urandom_range(span));
    return it;
  endfunction

  task automatic send_item(input mfqs_in_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_item(item);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_slice(input logic [SLICE_W-1:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    tracker.set_slice(value);
  endtask

  initial begin
    logic [SLICE_W-1:0] phase_slice [6];
    int unsigned        admit_pct;
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_data            = '0;
    out_ready          = 1'b0;
    cfg_valid          = 1'b0;
    cfg_data           = '0;
    send_idle_pct      = 22;
    recv_idle_pct      = 47;
    long_stall_pending = 1'b0;
    hold_left          = 0;
    phase_slice        = '{16'd1, 16'd65535, 16'd7, 16'd0, 16'd2, 16'd3};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(make_item(OP_DISPATCH, 0, 0, 0));
    send_item(make_item(OP_ADMIT, 0, 0, 0));
    send_item(make_item(OP_ADMIT, 7, 255, 65535));
    send_item(make_item(OP_ADMIT, 5, 1, 1));
    send_item(make_item(OP_ADMIT, 6, 2, 2));
    send_item(make_item(OP_ADMIT, 4, 8'hAA, 65535));
    send_item(make_item(OP_ADMIT, 0, 8'h55, 3));
    send_item(make_item(OP_DISPATCH, 7, 255, 65535));
    send_item(make_item(OP_DISPATCH, 0, 0, 0));
    for (int i = 0; i < DEPTH + 1; i++) begin
      send_item(make_item(OP_ADMIT, 1, 16 + i, 65535));
    end
    send_item(make_item(OP_DISPATCH, 0, 0, 0));

    for (int p = 0; p < 6; p++) begin
      write_slice(phase_slice[p]);
      send_idle_pct = (p < 2) ? 22 : (p < 4) ? 47 : 0;
      recv_idle_pct = (p < 2) ? 47 : (p < 4) ? 22 : 0;
      for (int n = 0; n < PHASE_LEN; n++) begin
        if (p == 0 && n == 100) long_stall_pending = 1'b1;
        admit_pct = ((n / 40) % 2 == 0) ? 70 : 35;
        send_item(random_item(admit_pct));
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.awaited_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (tracker.awaited_results.size() != 0) begin
      $error("%0d results never arrived", tracker.awaited_results.size());
      tracker.failures++;
    end
    if (tracker.failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
